@@ src/isu_pkg.sv @@
package isu_pkg;

	localparam int SITE_W      = 10;
	localparam int CNT_W       = 11;
	localparam int RND_W       = 32;
	localparam int THR_W       = 33;
	localparam int TOT_W       = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 33;
	localparam int DEF_MAX_SPINS = 1024;
	localparam int DEF_COUNT   = 1024;
	localparam int MIN_COUNT   = 2;

	localparam logic MODE_HEAT = 1'b1;
	localparam logic FUNC_LOAD = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE      = 3'd0,
		CFG_COUNT     = 3'd1,
		CFG_THR_UP_M2 = 3'd2,
		CFG_THR_UP_0  = 3'd3,
		CFG_THR_UP_P2 = 3'd4,
		CFG_THR_DN_M2 = 3'd5,
		CFG_THR_DN_0  = 3'd6,
		CFG_THR_DN_P2 = 3'd7
	} cfg_idx_t;

	// Threshold arrays are ordered by neighbor sum: -2, 0, +2.
	typedef struct packed {
		logic                       mode;
		logic [CNT_W-1:0]           count;
		logic [2:0][THR_W-1:0]      thr_up;
		logic [2:0][THR_W-1:0]      thr_dn;
	} cfg_t;

	typedef struct packed {
		logic                       new_spin;
		logic                       accepted;
		logic signed [TOT_W-1:0]    mag;
		logic signed [TOT_W-1:0]    bond;
	} dec_t;

endpackage

@@ src/isu_ram.sv @@
module isu_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/isu_cfg.sv @@
module isu_cfg #(
	parameter int MAX_SPINS = isu_pkg::DEF_MAX_SPINS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [isu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [isu_pkg::CFG_DATA_W-1:0]   cfg_data,
	output isu_pkg::cfg_t                    cfg,
	output logic                             clr_req
);

	localparam int RST_COUNT = (isu_pkg::DEF_COUNT < MAX_SPINS) ?
		isu_pkg::DEF_COUNT : MAX_SPINS;

	isu_pkg::cfg_t             cfg_q;
	logic [isu_pkg::CNT_W-1:0] count_clamped;

	// Ring length is clamped to at least MIN_COUNT and at most MAX_SPINS, the store depth.
	always_comb begin
		count_clamped = cfg_data[isu_pkg::CNT_W-1:0];
		if (count_clamped < isu_pkg::CNT_W'(isu_pkg::MIN_COUNT)) begin
			count_clamped = isu_pkg::CNT_W'(isu_pkg::MIN_COUNT);
		end
		if (int'(count_clamped) > MAX_SPINS) begin
			count_clamped = isu_pkg::CNT_W'(MAX_SPINS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= 1'b0;
			cfg_q.count  <= isu_pkg::CNT_W'(RST_COUNT);
			cfg_q.thr_up <= '0;
			cfg_q.thr_dn <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				isu_pkg::CFG_MODE:      cfg_q.mode      <= cfg_data[0];
				isu_pkg::CFG_COUNT:     cfg_q.count     <= count_clamped;
				isu_pkg::CFG_THR_UP_M2: cfg_q.thr_up[0] <= cfg_data;
				isu_pkg::CFG_THR_UP_0:  cfg_q.thr_up[1] <= cfg_data;
				isu_pkg::CFG_THR_UP_P2: cfg_q.thr_up[2] <= cfg_data;
				isu_pkg::CFG_THR_DN_M2: cfg_q.thr_dn[0] <= cfg_data;
				isu_pkg::CFG_THR_DN_0:  cfg_q.thr_dn[1] <= cfg_data;
				isu_pkg::CFG_THR_DN_P2: cfg_q.thr_dn[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg     = cfg_q;
	assign clr_req = cfg_we && (cfg_index == isu_pkg::CFG_COUNT);

endmodule

@@ src/isu_decide.sv @@
module isu_decide (
	input  isu_pkg::cfg_t                      cfg,
	input  logic                               func,
	input  logic [isu_pkg::RND_W-1:0]          rand_frac,
	input  logic                               load_value,
	input  logic                               spin_l,
	input  logic                               spin_old,
	input  logic                               spin_r,
	input  logic signed [isu_pkg::TOT_W-1:0]   mag,
	input  logic signed [isu_pkg::TOT_W-1:0]   bond,
	output isu_pkg::dec_t                      dec
);

	logic [isu_pkg::THR_W-1:0] thr_up_sel;
	logic [isu_pkg::THR_W-1:0] thr_dn_sel;
	logic [isu_pkg::THR_W-1:0] thr;
	logic                      pass;
	logic                      changed;

	// Both neighbors up (spin bit 0) means sum +2, both down means -2.
	always_comb begin
		case ({spin_l, spin_r})
			2'b00:   begin thr_up_sel = cfg.thr_up[2]; thr_dn_sel = cfg.thr_dn[2]; end
			2'b11:   begin thr_up_sel = cfg.thr_up[0]; thr_dn_sel = cfg.thr_dn[0]; end
			default: begin thr_up_sel = cfg.thr_up[1]; thr_dn_sel = cfg.thr_dn[1]; end
		endcase
	end

	always_comb begin
		thr  = (cfg.mode != isu_pkg::MODE_HEAT && spin_old) ? thr_dn_sel : thr_up_sel;
		pass = {1'b0, rand_frac} < thr;

		if (func == isu_pkg::FUNC_LOAD) begin
			dec.new_spin = load_value;
			dec.accepted = 1'b0;
		end else if (cfg.mode == isu_pkg::MODE_HEAT) begin
			dec.new_spin = pass;
			dec.accepted = 1'b1;
		end else begin
			dec.new_spin = spin_old ^ pass;
			dec.accepted = pass;
		end

		changed  = dec.new_spin != spin_old;
		dec.mag  = mag;
		dec.bond = bond;
		if (changed) begin
			dec.mag = dec.new_spin ? mag - isu_pkg::TOT_W'(2) : mag + isu_pkg::TOT_W'(2);
			// Bond change is nonzero only when both neighbors agree.
			if (spin_l == spin_r) begin
				dec.bond = (dec.new_spin ^ spin_l) ? bond - isu_pkg::TOT_W'(4) :
					bond + isu_pkg::TOT_W'(4);
			end
		end
	end

endmodule

@@ src/ising_ring_spin_update.sv @@
// Update item with a valid site: states RD_L, RD_S and RD_R read the spin memory
// through its single read port (left neighbor, site, right neighbor in turn),
// then EXEC registers the result once the output register is free; the next
// item is taken only back in IDLE. An item with a site outside the ring skips to EXEC.
// Reset, and every spin_count write, start a clearing pass over the spin_count
// sites (1024 by default) that sets all spins to +1; no item is taken meanwhile.
module ising_ring_spin_update #(
	parameter int MAX_SPINS = isu_pkg::DEF_MAX_SPINS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [isu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [isu_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  func,
	input  logic [isu_pkg::SITE_W-1:0]            site,
	input  logic [isu_pkg::RND_W-1:0]             rand_frac,
	input  logic                                  load_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [isu_pkg::SITE_W-1:0]            site_out,
	output logic                                  new_spin,
	output logic                                  accepted,
	output logic                                  bad_site,
	output logic signed [isu_pkg::TOT_W-1:0]      magnetization,
	output logic signed [isu_pkg::TOT_W-1:0]      bond_sum
);

	localparam int AW = $clog2(MAX_SPINS);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RD_L  = 6'b000100,
		ST_RD_S  = 6'b001000,
		ST_RD_R  = 6'b010000,
		ST_EXEC  = 6'b100000
	} state_t;

	isu_pkg::cfg_t cfg;
	logic          clr_req;
	isu_pkg::dec_t dec;

	state_t                             state_q;
	logic [isu_pkg::CNT_W-1:0]          clr_cnt_q;
	logic signed [isu_pkg::TOT_W-1:0]   mag_q;
	logic signed [isu_pkg::TOT_W-1:0]   bond_q;

	logic                               func_q;
	logic [isu_pkg::SITE_W-1:0]         site_q;
	logic [isu_pkg::RND_W-1:0]          rnd_q;
	logic                               load_q;
	logic                               bad_q;
	logic [AW-1:0]                      left_q;
	logic [AW-1:0]                      right_q;
	logic                               spin_l_q;
	logic                               spin_old_q;

	logic                               out_valid_q;
	logic [isu_pkg::SITE_W-1:0]         site_out_q;
	logic                               new_spin_q;
	logic                               accepted_q;
	logic                               bad_site_q;
	logic signed [isu_pkg::TOT_W-1:0]   mag_out_q;
	logic signed [isu_pkg::TOT_W-1:0]   bond_out_q;

	logic [isu_pkg::CNT_W-1:0] site_ext;
	logic [isu_pkg::CNT_W-1:0] left_nxt;
	logic [isu_pkg::CNT_W-1:0] right_nxt;
	logic                      in_take;
	logic                      load_out;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic                      ram_wdata;
	logic [AW-1:0]             ram_raddr;
	logic                      ram_rdata;

	isu_cfg #(.MAX_SPINS(MAX_SPINS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.clr_req   (clr_req)
	);

	isu_ram #(.WIDTH(1), .DEPTH(MAX_SPINS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	isu_decide u_decide (
		.cfg        (cfg),
		.func       (func_q),
		.rand_frac  (rnd_q),
		.load_value (load_q),
		.spin_l     (spin_l_q),
		.spin_old   (spin_old_q),
		.spin_r     (ram_rdata),
		.mag        (mag_q),
		.bond       (bond_q),
		.dec        (dec)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign load_out = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	always_comb begin
		site_ext  = isu_pkg::CNT_W'(site);
		left_nxt  = (site_ext == '0) ? cfg.count - 1'b1 : site_ext - 1'b1;
		right_nxt = (site_ext + 1'b1 == cfg.count) ? '0 : site_ext + 1'b1;
	end

	// The right neighbor address is held through the execute state so that
	// the read data stays put while the output register is full.
	always_comb begin
		case (state_q)
			ST_RD_L: ram_raddr = left_q;
			ST_RD_S: ram_raddr = AW'(site_q);
			default: ram_raddr = right_q;
		endcase
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(clr_cnt_q);
			ram_wdata = 1'b0;
		end else begin
			ram_we    = load_out && !bad_q;
			ram_waddr = AW'(site_q);
			ram_wdata = dec.new_spin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			mag_q       <= isu_pkg::TOT_W'(isu_pkg::DEF_COUNT);
			bond_q      <= isu_pkg::TOT_W'(isu_pkg::DEF_COUNT);
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (clr_req) begin
				state_q   <= ST_CLEAR;
				clr_cnt_q <= '0;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						mag_q  <= isu_pkg::TOT_W'(cfg.count);
						bond_q <= isu_pkg::TOT_W'(cfg.count);
						if (clr_cnt_q == cfg.count - 1'b1) begin
							state_q <= ST_IDLE;
						end
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
					ST_IDLE: begin
						if (in_take) begin
							state_q <= (site_ext >= cfg.count) ? ST_EXEC : ST_RD_L;
						end
					end
					ST_RD_L: state_q <= ST_RD_S;
					ST_RD_S: state_q <= ST_RD_R;
					ST_RD_R: state_q <= ST_EXEC;
					ST_EXEC: begin
						if (load_out) begin
							state_q <= ST_IDLE;
							if (!bad_q) begin
								mag_q  <= dec.mag;
								bond_q <= dec.bond;
							end
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_q  <= func;
			site_q  <= site;
			rnd_q   <= rand_frac;
			load_q  <= load_value;
			bad_q   <= site_ext >= cfg.count;
			left_q  <= AW'(left_nxt);
			right_q <= AW'(right_nxt);
		end
		if (state_q == ST_RD_S) begin
			spin_l_q <= ram_rdata;
		end
		if (state_q == ST_RD_R) begin
			spin_old_q <= ram_rdata;
		end
		if (load_out) begin
			site_out_q <= site_q;
			bad_site_q <= bad_q;
			new_spin_q <= bad_q ? 1'b0 : dec.new_spin;
			accepted_q <= bad_q ? 1'b0 : dec.accepted;
			mag_out_q  <= bad_q ? mag_q : dec.mag;
			bond_out_q <= bad_q ? bond_q : dec.bond;
		end
	end

	assign out_valid     = out_valid_q;
	assign site_out      = site_out_q;
	assign new_spin      = new_spin_q;
	assign accepted      = accepted_q;
	assign bad_site      = bad_site_q;
	assign magnetization = mag_out_q;
	assign bond_sum      = bond_out_q;

	// Every spin move changes the magnetization by two and the bond sum by zero or
	// four, so outside clearing their low bits (one and two) match the ring length.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |-> mag_q[0] == cfg.count[0])
		else $error("magnetization parity differs from ring length");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |-> bond_q[1:0] == cfg.count[1:0])
		else $error("bond sum differs from ring length modulo four");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> clr_cnt_q < cfg.count)
		else $error("clearing pass ran past the ring length");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && bad_site_q |-> !accepted_q && !new_spin_q)
		else $error("ignored site reports a spin change");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_CLEAR || load_out)
		else $error("spin memory written outside clearing or result load");

endmodule
